// ===== rtl/evfg_pkg.sv =====
// Shared types, codes and helpers of the event flag group.
`default_nettype none
package evfg_pkg;

    localparam int FLAG_BITS       = 24;
    localparam int TASK_W          = 4;
    localparam int PRIO_W          = 5;
    localparam int MODE_W          = 3;
    localparam int WMODE_W         = 2;
    localparam int STAT_W          = 3;
    localparam int WAITERS_DEF     = 16;
    localparam int PRIO_LEVELS_DEF = 32;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNSAT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_QUEUED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETED = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECT  = 3'd4;

    // wait mode bit positions
    localparam int WM_ALL = 0;
    localparam int WM_CLR = 1;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [FLAG_BITS-1:0] bits;
        logic [WMODE_W-1:0]   wait_mode;
        logic                 may_block;
        logic [TASK_W-1:0]    task_id;
        logic [PRIO_W-1:0]    priority_req;
    } t_in_word;

    typedef struct packed {
        logic [TASK_W-1:0]    task_id_out;
        logic [STAT_W-1:0]    status;
        logic [FLAG_BITS-1:0] rpt_flags;
        logic [FLAG_BITS-1:0] flags_now;
        logic                 last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic wake;
        logic del_emit;
        logic scan;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_set;
        logic op_del;
        logic at_end;
        logic sat;
        logic slot_free;
    } t_stat;

    function automatic logic cond_met(input logic [FLAG_BITS-1:0] flags,
                                      input logic [FLAG_BITS-1:0] mask,
                                      input logic all);
        if (all) begin
            return (flags & mask) == mask;
        end
        return (flags & mask) != '0;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/evfg_ctrl.sv =====
// Sequencer of the event flag group: accept, walk the table, final reply.
`default_nettype none
module evfg_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [evfg_pkg::MODE_W-1:0] i_in_mode,
    input  wire evfg_pkg::t_stat            i_st,
    output evfg_pkg::t_cmd                  o_cmd,
    output logic                            o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // decide the next step
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_mode == evfg_pkg::MODE_SET || i_in_mode == evfg_pkg::MODE_WAIT
                        || i_in_mode == evfg_pkg::MODE_CANCEL
                        || i_in_mode == evfg_pkg::MODE_DELETE) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_WALK: begin
                if (i_st.at_end) begin
                    n_state = S_FIN;
                end else if (i_st.op_set) begin
                    if (!i_st.sat) begin
                        o_cmd.step = 1'b1;
                    end else if (i_st.slot_free) begin
                        o_cmd.wake = 1'b1;
                    end
                end else if (i_st.op_del) begin
                    o_cmd.del_emit = i_st.slot_free;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_FIN: begin
                if (i_st.slot_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/evfg_dp.sv =====
// Datapath of the event flag group: flags, waiter table, output register.
`default_nettype none
module evfg_dp #(
    parameter int WAITERS     = evfg_pkg::WAITERS_DEF,
    parameter int PRIO_LEVELS = evfg_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire evfg_pkg::t_in_word i_in,
    input  wire evfg_pkg::t_cmd     i_cmd,
    output evfg_pkg::t_stat         o_st,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output evfg_pkg::t_out_word     o_out
);

    localparam int IW    = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int CW    = $clog2(WAITERS + 1);
    localparam int PL_M1 = PRIO_LEVELS - 1;
    localparam int FB    = evfg_pkg::FLAG_BITS;

    // latched request
    logic [evfg_pkg::MODE_W-1:0]  r_op;
    logic [FB-1:0]                r_bits;
    logic [evfg_pkg::WMODE_W-1:0] r_wm;
    logic                         r_blk;
    logic [evfg_pkg::TASK_W-1:0]  r_task;
    logic [evfg_pkg::PRIO_W-1:0]  r_prio;

    // flags and waiter table
    logic [FB-1:0]                r_flags;
    logic [evfg_pkg::TASK_W-1:0]  r_t_task [WAITERS];
    logic [evfg_pkg::PRIO_W-1:0]  r_t_prio [WAITERS];
    logic [FB-1:0]                r_t_mask [WAITERS];
    logic [evfg_pkg::WMODE_W-1:0] r_t_wm   [WAITERS];
    logic [CW-1:0]                r_count;

    // walk state
    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic          r_pfound;
    logic [IW-1:0] r_pos;

    logic                r_ov;
    evfg_pkg::t_out_word r_out;

    logic [evfg_pkg::TASK_W-1:0]  e_task;
    logic [evfg_pkg::PRIO_W-1:0]  e_prio;
    logic [FB-1:0]                e_mask;
    logic [evfg_pkg::WMODE_W-1:0] e_wm;
    logic                         slot_free;
    logic [evfg_pkg::PRIO_W-1:0]  in_prio;

    logic                rem;
    logic [IW-1:0]       rem_i;
    logic                ins;
    logic                emit;
    evfg_pkg::t_out_word n_out;
    logic [FB-1:0]       n_flags;
    logic [FB-1:0]       wake_flags;

    // read the entry under the walk pointer
    assign e_task = r_t_task[r_idx[IW-1:0]];
    assign e_prio = r_t_prio[r_idx[IW-1:0]];
    assign e_mask = r_t_mask[r_idx[IW-1:0]];
    assign e_wm   = r_t_wm[r_idx[IW-1:0]];

    assign slot_free = !r_ov || !i_out_stall;
    assign in_prio   = ({3'b000, i_in.priority_req} >= 8'(PRIO_LEVELS > 255 ? 255 : PRIO_LEVELS))
                       ? evfg_pkg::PRIO_W'(PL_M1) : i_in.priority_req;

    assign o_st.op_set    = (r_op == evfg_pkg::MODE_SET);
    assign o_st.op_del    = (r_op == evfg_pkg::MODE_DELETE);
    assign o_st.at_end    = (r_idx >= r_count);
    assign o_st.sat       = evfg_pkg::cond_met(r_flags, e_mask, e_wm[evfg_pkg::WM_ALL]);
    assign o_st.slot_free = slot_free;

    assign wake_flags = e_wm[evfg_pkg::WM_CLR] ? (r_flags & ~e_mask) : r_flags;

    // build the result word and the table change
    always_comb begin
        rem     = 1'b0;
        rem_i   = r_idx[IW-1:0];
        ins     = 1'b0;
        emit    = 1'b0;
        n_flags = r_flags;
        n_out   = '0;
        if (i_cmd.wake) begin
            emit    = 1'b1;
            rem     = 1'b1;
            n_flags = wake_flags;
            n_out   = '{e_task, evfg_pkg::ST_DONE, r_flags, wake_flags, 1'b0};
        end else if (i_cmd.del_emit) begin
            emit  = 1'b1;
            n_out = '{e_task, evfg_pkg::ST_DELETED, '0, '0, 1'b0};
        end else if (i_cmd.fin) begin
            emit  = 1'b1;
            n_out = '{r_task, evfg_pkg::ST_REJECT, r_flags, r_flags, 1'b1};
            unique case (r_op)
                evfg_pkg::MODE_SET: begin
                    n_out.status = evfg_pkg::ST_DONE;
                end
                evfg_pkg::MODE_CLEAR: begin
                    n_flags         = r_flags & ~r_bits;
                    n_out.status    = evfg_pkg::ST_DONE;
                    n_out.rpt_flags = n_flags;
                    n_out.flags_now = n_flags;
                end
                evfg_pkg::MODE_WAIT: begin
                    if (r_bits == '0 || r_found) begin
                        n_out.status = evfg_pkg::ST_REJECT;
                    end else if (evfg_pkg::cond_met(r_flags, r_bits, r_wm[evfg_pkg::WM_ALL])) begin
                        if (r_wm[evfg_pkg::WM_CLR]) begin
                            n_flags = r_flags & ~r_bits;
                        end
                        n_out.status    = evfg_pkg::ST_DONE;
                        n_out.flags_now = n_flags;
                    end else if (!r_blk) begin
                        n_out.status = evfg_pkg::ST_UNSAT;
                    end else if (r_count >= CW'(WAITERS)) begin
                        n_out.status = evfg_pkg::ST_REJECT;
                    end else begin
                        ins          = 1'b1;
                        n_out.status = evfg_pkg::ST_QUEUED;
                    end
                end
                evfg_pkg::MODE_CANCEL: begin
                    if (r_found) begin
                        rem          = 1'b1;
                        rem_i        = r_fidx;
                        n_out.status = evfg_pkg::ST_UNSAT;
                    end
                end
                evfg_pkg::MODE_DELETE: begin
                    n_out = '{r_task, evfg_pkg::ST_DONE, '0, '0, 1'b1};
                end
                default: n_out.status = evfg_pkg::ST_REJECT;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.load) begin
                if (i_in.mode == evfg_pkg::MODE_SET) begin
                    r_flags <= r_flags | i_in.bits;
                end else if (i_in.mode == evfg_pkg::MODE_DELETE) begin
                    r_flags <= '0;
                end
            end else begin
                r_flags <= n_flags;
            end
            if (rem) begin
                r_count <= r_count - 1'b1;
            end else if (ins) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.fin && r_op == evfg_pkg::MODE_DELETE) begin
                r_count <= '0;
            end
        end
    end

    // payload registers: request, walk, table, output word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
        if (i_cmd.load) begin
            r_op     <= i_in.mode;
            r_bits   <= i_in.bits;
            r_wm     <= i_in.wait_mode;
            r_blk    <= i_in.may_block;
            r_task   <= i_in.task_id;
            r_prio   <= in_prio;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_pfound <= 1'b0;
            r_pos    <= r_count[IW-1:0];
        end
        if (i_cmd.step || i_cmd.del_emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (e_task == r_task) begin
                r_found <= 1'b1;
                r_fidx  <= r_idx[IW-1:0];
            end
            if (!r_pfound && e_prio < r_prio) begin
                r_pfound <= 1'b1;
                r_pos    <= r_idx[IW-1:0];
            end
        end
        // close the gap left by a removed waiter
        if (rem) begin
            for (int j = 0; j < WAITERS - 1; j++) begin
                if (IW'(j) >= rem_i) begin
                    r_t_task[j] <= r_t_task[j+1];
                    r_t_prio[j] <= r_t_prio[j+1];
                    r_t_mask[j] <= r_t_mask[j+1];
                    r_t_wm[j]   <= r_t_wm[j+1];
                end
            end
        end
        // open a slot and place the new waiter
        if (ins) begin
            for (int j = 1; j < WAITERS; j++) begin
                if (IW'(j) > r_pos) begin
                    r_t_task[j] <= r_t_task[j-1];
                    r_t_prio[j] <= r_t_prio[j-1];
                    r_t_mask[j] <= r_t_mask[j-1];
                    r_t_wm[j]   <= r_t_wm[j-1];
                end
            end
            r_t_task[r_pos] <= r_task;
            r_t_prio[r_pos] <= r_prio;
            r_t_mask[r_pos] <= r_bits;
            r_t_wm[r_pos]   <= r_wm;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== rtl/event_flag_group_waiters.sv =====
// Event flag group with a priority-ordered table of waiting tasks.
//
// Input channel i_in (i_in_valid / o_in_stall) carries one request word:
// set, clear, wait, cancel or delete. Output channel o_out (o_out_valid /
// i_out_stall) returns one or more result words per request; the final one
// has last set. One request is handled at a time; o_in_stall is high from
// acceptance until the final result has been written to the output register.
// Set and delete walk the table one waiter per cycle, emitting a result per
// woken waiter; wait and cancel scan the table one entry per cycle to find a
// duplicate task and the insert position. Clear and an unknown mode do not
// walk the table. While the receiver stalls the result word holds and the
// walk pauses at the next emit. Reset clears the flags, the waiter count and
// all control state; table entries are only read below the count, so they
// need no clearing.
`default_nettype none
module event_flag_group_waiters #(
    parameter int WAITERS     = evfg_pkg::WAITERS_DEF,
    parameter int PRIO_LEVELS = evfg_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire evfg_pkg::t_in_word  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output evfg_pkg::t_out_word      o_out
);

    evfg_pkg::t_cmd  w_cmd;
    evfg_pkg::t_stat w_st;
    logic            w_busy;

    evfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in.mode),
        .i_st       (w_st),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    evfg_dp #(
        .WAITERS     (WAITERS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign o_in_stall = w_busy;

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step, w_cmd.wake, w_cmd.del_emit, w_cmd.scan, w_cmd.fin}))
        else $error("more than one command issued");

    // results are only produced into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wake || w_cmd.del_emit || w_cmd.fin) |-> w_st.slot_free)
        else $error("result written over a pending word");

    // the final reply shows up with last set
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |=> (o_out_valid && o_out.last))
        else $error("final reply missing last");

    // work commands only while a request is in progress
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(w_cmd.step || w_cmd.wake || w_cmd.del_emit || w_cmd.scan || w_cmd.fin))
        else $error("work command while idle");

endmodule
`default_nettype wire
